[rtl/core/ufwd_pkg.sv]
`timescale 1ns / 1ps
// Package for the per-user flood window detector.
// Holds the configuration struct, register offsets and input codes; no dependencies.

package ufwd_pkg;

  // Fixed field widths of the input and result transactions.
  localparam int SLOT_W    = 8;
  localparam int KIND_W    = 2;
  localparam int ACTION_W  = 3;
  localparam int WEIGHT_W  = 12;
  localparam int THRESH_W  = 16;
  localparam int WINDOW_W  = 20;
  localparam int ELAPSED_W = 21;

  // APB register file geometry: six 32-bit registers at word offsets.
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  // Register indexes (paddr[4:2]).
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ACTION    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PRIVMSG_W = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NOTICE_W  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_TAGMSG_W  = 3'd5;

  // Input codes.
  localparam logic MODE_MSG  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [KIND_W-1:0] KIND_PRIVMSG = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NOTICE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TAGMSG  = 2'd2;

  // Current configuration as seen by the update engine.
  typedef struct packed {
    logic [THRESH_W-1:0] threshold_messages;
    logic [WINDOW_W-1:0] window_seconds;
    logic [ACTION_W-1:0] action_code;
    logic [WEIGHT_W-1:0] privmsg_weight;
    logic [WEIGHT_W-1:0] notice_weight;
    logic [WEIGHT_W-1:0] tagmsg_weight;
  } cfg_t;

endpackage

[rtl/core/ufwd_ram.sv]
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; used for the per-user counter table.

module ufwd_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the read data is registered and appears in the cycle after rd_en.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/ufwd_cfg.sv]
`timescale 1ns / 1ps
// APB register file holding the detector configuration.
// Depends on ufwd_pkg for the register map and the configuration struct.

module ufwd_cfg #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ufwd_pkg::ADDR_W-1:0]         paddr,
  input  logic [ufwd_pkg::DATA_W-1:0]         pwdata,
  output logic [ufwd_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  output ufwd_pkg::cfg_t                      cfg
);

  import ufwd_pkg::*;

  // Reset weights: 1.0 and 0.2 (rounded to nearest) in the chosen fixed point.
  localparam int unsigned ONE_FIXED   = 1 << FRAC_BITS;
  localparam int unsigned FIFTH_FIXED = (ONE_FIXED * 2 + 5) / 10;
  localparam logic [WEIGHT_W-1:0] ONE_RST   = WEIGHT_W'(ONE_FIXED);
  localparam logic [WEIGHT_W-1:0] FIFTH_RST = WEIGHT_W'(FIFTH_FIXED);

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic                 wr_stb;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_stb  = psel & penable & pwrite & pready;

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_stb) begin
      case (reg_idx)
        REG_THRESHOLD: cfg_nxt.threshold_messages = pwdata[THRESH_W-1:0];
        REG_WINDOW:    cfg_nxt.window_seconds     = pwdata[WINDOW_W-1:0];
        REG_ACTION:    cfg_nxt.action_code        = pwdata[ACTION_W-1:0];
        REG_PRIVMSG_W: cfg_nxt.privmsg_weight     = pwdata[WEIGHT_W-1:0];
        REG_NOTICE_W:  cfg_nxt.notice_weight      = pwdata[WEIGHT_W-1:0];
        REG_TAGMSG_W:  cfg_nxt.tagmsg_weight      = pwdata[WEIGHT_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_messages <= THRESH_W'(10);
      cfg_r.window_seconds     <= WINDOW_W'(60);
      cfg_r.action_code        <= ACTION_W'(1);
      cfg_r.privmsg_weight     <= ONE_RST;
      cfg_r.notice_weight      <= ONE_RST;
      cfg_r.tagmsg_weight      <= FIFTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux; unused offsets read as zero.
  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = DATA_W'(cfg_r.threshold_messages);
      REG_WINDOW:    prdata = DATA_W'(cfg_r.window_seconds);
      REG_ACTION:    prdata = DATA_W'(cfg_r.action_code);
      REG_PRIVMSG_W: prdata = DATA_W'(cfg_r.privmsg_weight);
      REG_NOTICE_W:  prdata = DATA_W'(cfg_r.notice_weight);
      REG_TAGMSG_W:  prdata = DATA_W'(cfg_r.tagmsg_weight);
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/ufwd_engine.sv]
`timescale 1ns / 1ps
// Read-modify-write engine: window tracking, per-user valid bits and counter update.
// Depends on ufwd_pkg; drives the ports of the counter RAM instantiated in the top level.

module ufwd_engine #(
  parameter int USER_SLOTS = 256,
  parameter int FRAC_BITS  = 8,
  parameter int IDX_W      = $clog2(USER_SLOTS),
  parameter int COUNT_W    = 17 + FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ufwd_pkg::cfg_t                cfg,
  // Input transaction.
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic [ufwd_pkg::SLOT_W-1:0]   in_user_slot,
  input  logic [ufwd_pkg::KIND_W-1:0]   in_message_kind,
  // Result transaction.
  output logic                          out_strobe,
  output logic                          out_flood_triggered,
  output logic [ufwd_pkg::ACTION_W-1:0] out_action_out,
  output logic [ufwd_pkg::SLOT_W-1:0]   out_user_out,
  // Counter RAM.
  output logic                          mem_rd_en,
  output logic [IDX_W-1:0]              mem_rd_addr,
  input  logic [COUNT_W-1:0]            mem_rd_data,
  output logic                          mem_wr_en,
  output logic [IDX_W-1:0]              mem_wr_addr,
  output logic [COUNT_W-1:0]            mem_wr_data
);

  import ufwd_pkg::*;

  localparam int SLOT_VALUES = 1 << SLOT_W;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Slot to table index, worked out at elaboration (slot modulo USER_SLOTS).
  logic [IDX_W-1:0] idx_tbl [SLOT_VALUES];
  genvar g;
  for (g = 0; g < SLOT_VALUES; g++) begin : g_idx
    assign idx_tbl[g] = IDX_W'(g % USER_SLOTS);
  end

  logic [ELAPSED_W-1:0]  elapsed_r, elapsed_nxt;
  logic [USER_SLOTS-1:0] valid_r, valid_nxt;
  logic                  s1_vld_r;
  logic                  s1_cvalid_r;
  logic [IDX_W-1:0]      s1_idx_r;
  logic [SLOT_W-1:0]     s1_slot_r;
  logic [WEIGHT_W-1:0]   s1_weight_r;
  logic                  out_strobe_r;
  logic                  out_trig_r;
  logic [ACTION_W-1:0]   out_action_r;
  logic [SLOT_W-1:0]     out_user_r;

  logic                  accept, msg_accept, tick_accept, restart;
  logic [IDX_W-1:0]      in_idx;
  logic [WEIGHT_W-1:0]   in_weight;
  logic [COUNT_W-1:0]    s1_count, s1_sat, s1_limit;
  logic [COUNT_W:0]      s1_sum;
  logic                  s1_hit;

  // Transaction acceptance; one message is in flight at a time.
  assign busy        = s1_vld_r;
  assign accept      = start & ~busy;
  assign msg_accept  = accept & (in_mode == MODE_MSG);
  assign tick_accept = accept & (in_mode == MODE_TICK);
  assign restart     = elapsed_r > ELAPSED_W'(cfg.window_seconds);
  assign in_idx      = idx_tbl[in_user_slot];

  // Weight of the message kind; the unused kind weighs nothing.
  always_comb begin
    case (in_message_kind)
      KIND_PRIVMSG: in_weight = cfg.privmsg_weight;
      KIND_NOTICE:  in_weight = cfg.notice_weight;
      KIND_TAGMSG:  in_weight = cfg.tagmsg_weight;
      default:      in_weight = '0;
    endcase
  end

  // Stage one: the counter arrives from the RAM; add, saturate and compare.
  assign s1_count = s1_cvalid_r ? mem_rd_data : '0;
  assign s1_sum   = {1'b0, s1_count} + (COUNT_W+1)'(s1_weight_r);
  assign s1_sat   = s1_sum[COUNT_W] ? '1 : s1_sum[COUNT_W-1:0];
  assign s1_limit = {1'b0, cfg.threshold_messages, {FRAC_BITS{1'b0}}};
  assign s1_hit   = s1_sat >= s1_limit;

  // Counter RAM accesses: read on accept, write back in the following cycle.
  assign mem_rd_en   = msg_accept;
  assign mem_rd_addr = in_idx;
  assign mem_wr_en   = s1_vld_r;
  assign mem_wr_addr = s1_idx_r;
  assign mem_wr_data = s1_hit ? '0 : s1_sat;

  // Elapsed-window counter: ticks saturate, a late message restarts it.
  always_comb begin
    elapsed_nxt = elapsed_r;
    if (tick_accept && elapsed_r != ELAPSED_MAX) begin
      elapsed_nxt = elapsed_r + ELAPSED_W'(1);
    end else if (msg_accept && restart) begin
      elapsed_nxt = '0;
    end
  end

  // Valid bits: a restart clears them all, a write-back sets or clears one.
  always_comb begin
    valid_nxt = valid_r;
    if (msg_accept && restart) begin
      valid_nxt = '0;
    end
    if (s1_vld_r) begin
      valid_nxt[s1_idx_r] = ~s1_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r    <= '0;
      valid_r      <= '0;
      s1_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      out_trig_r   <= 1'b0;
      out_action_r <= '0;
    end else begin
      elapsed_r    <= elapsed_nxt;
      valid_r      <= valid_nxt;
      s1_vld_r     <= msg_accept;
      out_strobe_r <= s1_vld_r;
      out_trig_r   <= s1_vld_r & s1_hit;
      out_action_r <= (s1_vld_r && s1_hit) ? cfg.action_code : '0;
    end
  end

  // Message payload captured for stage one.
  always_ff @(posedge clk) begin
    if (msg_accept) begin
      s1_cvalid_r <= restart ? 1'b0 : valid_r[in_idx];
      s1_idx_r    <= in_idx;
      s1_slot_r   <= in_user_slot;
      s1_weight_r <= in_weight;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      out_user_r <= s1_slot_r;
    end
  end

  assign out_strobe          = out_strobe_r;
  assign out_flood_triggered = out_trig_r;
  assign out_action_out      = out_action_r;
  assign out_user_out        = out_user_r;

  // A message yields a result through the s1_vld_r and out_strobe_r registers.
  a_msg_result: assert property (@(posedge clk) disable iff (!rst_n)
    msg_accept |-> ##2 out_strobe_r)
    else $error("message transaction produced no result");

  // A tick yields no result.
  a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    tick_accept |-> ##2 !out_strobe_r)
    else $error("tick transaction produced a result");

  // A restart empties the window and every user counter.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (msg_accept && restart) |=> (elapsed_r == '0 && valid_r == '0))
    else $error("window restart did not clear state");

  // A trigger leaves that user's counter invalid.
  a_hit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_hit) |=> !valid_r[s1_idx_r])
    else $error("triggered user counter still valid");

  // The read-modify-write never overlaps a second message.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |=> !s1_vld_r)
    else $error("two messages in flight");

endmodule

[rtl/core/per_user_flood_window_detector.sv]
`timescale 1ns / 1ps
// Channel        | Direction | Handshake               | Payload
// input command  | in        | start, busy             | in_mode, in_user_slot, in_message_kind
// result         | out       | out_strobe (no stall)   | out_flood_triggered, out_action_out,
//                |           |                         | out_user_out
// configuration  | in/out    | APB psel/penable/pready | paddr, pwdata, prdata
//
// A tick only advances the window counter. A message takes the counter RAM read,
// then the add/compare and write-back, during which busy is high; its result is then
// registered onto out_strobe. Busy holds off a new transaction until the write-back.
// Reset (rst_n low, synchronous) clears the window, the valid bits and the strobe;
// no clearing pass is needed. The receiver cannot stall: out_strobe lasts one cycle.
// Top level of the per-user flood window detector; uses ufwd_pkg, ufwd_cfg,
// ufwd_engine and ufwd_ram.

module per_user_flood_window_detector #(
  parameter int USER_SLOTS = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input command.
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic [ufwd_pkg::SLOT_W-1:0]   in_user_slot,
  input  logic [ufwd_pkg::KIND_W-1:0]   in_message_kind,
  // Result.
  output logic                          out_strobe,
  output logic                          out_flood_triggered,
  output logic [ufwd_pkg::ACTION_W-1:0] out_action_out,
  output logic [ufwd_pkg::SLOT_W-1:0]   out_user_out,
  // Configuration.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ufwd_pkg::ADDR_W-1:0]   paddr,
  input  logic [ufwd_pkg::DATA_W-1:0]   pwdata,
  output logic [ufwd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  import ufwd_pkg::*;

  localparam int IDX_W   = $clog2(USER_SLOTS);
  localparam int COUNT_W = 17 + FRAC_BITS;

  cfg_t               cfg;
  logic               mem_rd_en, mem_wr_en;
  logic [IDX_W-1:0]   mem_rd_addr, mem_wr_addr;
  logic [COUNT_W-1:0] mem_rd_data, mem_wr_data;

  // Configuration registers.
  ufwd_cfg #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Per-user weighted counters.
  ufwd_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (USER_SLOTS)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Window tracking and counter update.
  ufwd_engine #(
    .USER_SLOTS (USER_SLOTS),
    .FRAC_BITS  (FRAC_BITS),
    .IDX_W      (IDX_W),
    .COUNT_W    (COUNT_W)
  ) u_engine (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_user_slot        (in_user_slot),
    .in_message_kind     (in_message_kind),
    .out_strobe          (out_strobe),
    .out_flood_triggered (out_flood_triggered),
    .out_action_out      (out_action_out),
    .out_user_out        (out_user_out),
    .mem_rd_en           (mem_rd_en),
    .mem_rd_addr         (mem_rd_addr),
    .mem_rd_data         (mem_rd_data),
    .mem_wr_en           (mem_wr_en),
    .mem_wr_addr         (mem_wr_addr),
    .mem_wr_data         (mem_wr_data)
  );

endmodule

[dv/per_user_flood_window_detector_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the per-user flood window detector.
// Drives message and tick transactions plus APB register writes; depends on ufwd_pkg
// and the per_user_flood_window_detector top level.

module per_user_flood_window_detector_tb;

  import ufwd_pkg::*;

  localparam int USER_SLOTS  = 256;
  localparam int FRAC_BITS   = 8;
  localparam int COUNT_W     = 17 + FRAC_BITS;
  localparam int ONE_FIXED   = 1 << FRAC_BITS;
  localparam int FIFTH_FIXED = (ONE_FIXED * 2 + 5) / 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4;

  // Kind code with no defined weight; the block treats it as weight zero.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic                triggered;
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   user;
  } flood_verdict_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_mode;
  logic [SLOT_W-1:0]   in_user_slot;
  logic [KIND_W-1:0]   in_message_kind;
  logic                out_strobe;
  logic                out_flood_triggered;
  logic [ACTION_W-1:0] out_action_out;
  logic [SLOT_W-1:0]   out_user_out;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Shadow copy of the block's configuration and counter state.
  cfg_t                shadow_cfg;
  logic [COUNT_W-1:0]  slot_tally [USER_SLOTS];
  bit                  slot_tally_live [USER_SLOTS];
  logic [ELAPSED_W-1:0] window_age;

  flood_verdict_t      verdicts_due [$];
  int                  failures;
  int                  idle_pct;
  int unsigned         cycle_count;

  per_user_flood_window_detector #(
    .USER_SLOTS(USER_SLOTS),
    .FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_mode            (in_mode),
    .in_user_slot       (in_user_slot),
    .in_message_kind    (in_message_kind),
    .out_strobe         (out_strobe),
    .out_flood_triggered(out_flood_triggered),
    .out_action_out     (out_action_out),
    .out_user_out       (out_user_out),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #4 clk = ~clk;

  // The run ends with a failure if it takes far longer than any correct run could.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void note_failure(input string what);
    failures++;
    if (failures <= 10) $display("%0t: %s", $time, what);
  endfunction

  function automatic void reset_shadow();
    shadow_cfg.threshold_messages = THRESH_W'(10);
    shadow_cfg.window_seconds     = WINDOW_W'(60);
    shadow_cfg.action_code        = ACTION_W'(1);
    shadow_cfg.privmsg_weight     = WEIGHT_W'(ONE_FIXED);
    shadow_cfg.notice_weight      = WEIGHT_W'(ONE_FIXED);
    shadow_cfg.tagmsg_weight      = WEIGHT_W'(FIFTH_FIXED);
    foreach (slot_tally[i]) begin
      slot_tally[i]      = '0;
      slot_tally_live[i] = 1'b0;
    end
    window_age = '0;
  endfunction

  function automatic logic [DATA_W-1:0] shadow_reg(input logic [REG_IDX_W-1:0] idx);
    logic [DATA_W-1:0] value;
    value = '0;
    case (idx)
      REG_THRESHOLD: value = DATA_W'(shadow_cfg.threshold_messages);
      REG_WINDOW:    value = DATA_W'(shadow_cfg.window_seconds);
      REG_ACTION:    value = DATA_W'(shadow_cfg.action_code);
      REG_PRIVMSG_W: value = DATA_W'(shadow_cfg.privmsg_weight);
      REG_NOTICE_W:  value = DATA_W'(shadow_cfg.notice_weight);
      REG_TAGMSG_W:  value = DATA_W'(shadow_cfg.tagmsg_weight);
      default:       value = '0;
    endcase
    return value;
  endfunction

  // Advances the shadow state by one accepted transaction and queues the verdict
  // that a message must produce.
  function automatic void step_flood_window(input logic mode, input logic [SLOT_W-1:0] slot,
                                            input logic [KIND_W-1:0] kind);
    logic [WEIGHT_W-1:0]           weight;
    logic [COUNT_W:0]              acc;
    logic [THRESH_W+FRAC_BITS-1:0] limit;
    int                            idx;
    flood_verdict_t                verdict;
    if (mode == MODE_TICK) begin
      if (window_age != '1) window_age++;
    end else begin
      // An expired window wipes every user's count before this message is counted.
      if (window_age > ELAPSED_W'(shadow_cfg.window_seconds)) begin
        foreach (slot_tally_live[i]) slot_tally_live[i] = 1'b0;
        window_age = '0;
      end
      case (kind)
        KIND_PRIVMSG: weight = shadow_cfg.privmsg_weight;
        KIND_NOTICE:  weight = shadow_cfg.notice_weight;
        KIND_TAGMSG:  weight = shadow_cfg.tagmsg_weight;
        default:      weight = '0;
      endcase
      idx = int'(slot) % USER_SLOTS;
      acc = slot_tally_live[idx] ? {1'b0, slot_tally[idx]} : '0;
      acc = acc + weight;
      if (acc[COUNT_W]) acc = {1'b0, {COUNT_W{1'b1}}};
      limit = {shadow_cfg.threshold_messages, {FRAC_BITS{1'b0}}};
      verdict.triggered = (acc >= limit);
      verdict.action    = verdict.triggered ? shadow_cfg.action_code : '0;
      verdict.user      = slot;
      if (verdict.triggered) begin
        slot_tally_live[idx] = 1'b0;
        slot_tally[idx]      = '0;
      end else begin
        slot_tally_live[idx] = 1'b1;
        slot_tally[idx]      = acc[COUNT_W-1:0];
      end
      verdicts_due = {verdicts_due, verdict};
    end
  endfunction

  // Checks each strobed result first, then records the transaction accepted at this edge.
  always @(posedge clk) begin : watch_ports
    flood_verdict_t seen;
    flood_verdict_t due;
    if (rst_n) begin
      if (out_strobe) begin
        seen = {out_flood_triggered, out_action_out, out_user_out};
        if (verdicts_due.size() == 0) begin
          note_failure($sformatf("unexpected result trig=%0b action=%0d user=%0d",
                                 seen.triggered, seen.action, seen.user));
        end else begin
          due = verdicts_due.pop_front();
          if (seen.triggered !== due.triggered || seen.action !== due.action ||
              seen.user !== due.user) begin
            note_failure($sformatf(
              "mismatch: expected trig=%0b action=%0d user=%0d, got trig=%0b action=%0d user=%0d",
              due.triggered, due.action, due.user, seen.triggered, seen.action, seen.user));
          end
        end
      end
      if (start && !busy) step_flood_window(in_mode, in_user_slot, in_message_kind);
    end
  end

  // Presents one transaction after a random gap and returns at the edge that accepts it.
  task automatic send_event(input logic mode, input logic [SLOT_W-1:0] slot,
                            input logic [KIND_W-1:0] kind);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_mode         <= mode;
    in_user_slot    <= slot;
    in_message_kind <= kind;
    do @(posedge clk); while (busy);
  endtask

  // Stops sending and waits until every message has reported and the pipeline is empty.
  task automatic settle();
    start <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic write_cfg_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_THRESHOLD: shadow_cfg.threshold_messages = value[THRESH_W-1:0];
      REG_WINDOW:    shadow_cfg.window_seconds     = value[WINDOW_W-1:0];
      REG_ACTION:    shadow_cfg.action_code        = value[ACTION_W-1:0];
      REG_PRIVMSG_W: shadow_cfg.privmsg_weight     = value[WEIGHT_W-1:0];
      REG_NOTICE_W:  shadow_cfg.notice_weight      = value[WEIGHT_W-1:0];
      REG_TAGMSG_W:  shadow_cfg.tagmsg_weight      = value[WEIGHT_W-1:0];
      default: ;
    endcase
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== shadow_reg(idx))
      note_failure($sformatf("register %0d reads %0h, expected %0h",
                             idx, prdata, shadow_reg(idx)));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_detector(input int thr, input int win, input int act,
                                  input int priv_w, input int notice_w, input int tag_w);
    write_cfg_reg(REG_THRESHOLD, DATA_W'(thr));
    write_cfg_reg(REG_WINDOW,    DATA_W'(win));
    write_cfg_reg(REG_ACTION,    DATA_W'(act));
    write_cfg_reg(REG_PRIVMSG_W, DATA_W'(priv_w));
    write_cfg_reg(REG_NOTICE_W,  DATA_W'(notice_w));
    write_cfg_reg(REG_TAGMSG_W,  DATA_W'(tag_w));
  endtask

  // Reset defaults with the extremes of every input field, the unused kind included.
  task automatic test_field_extremes();
    idle_pct = 0;
    send_event(MODE_MSG, 8'h00, KIND_PRIVMSG);
    send_event(MODE_MSG, 8'hFF, KIND_NOTICE);
    send_event(MODE_MSG, 8'h55, KIND_TAGMSG);
    send_event(MODE_MSG, 8'hAA, KIND_UNUSED);
    send_event(MODE_TICK, 8'hFF, KIND_UNUSED);
    settle();
  endtask

  // A threshold of zero fires on everything, one fires on a single full message,
  // and the largest threshold never fires with the heaviest weights.
  task automatic test_threshold_edges();
    idle_pct = 27;
    write_cfg_reg(REG_THRESHOLD, 32'd0);
    send_event(MODE_MSG, 8'd7, KIND_UNUSED);
    send_event(MODE_MSG, 8'd7, KIND_PRIVMSG);
    settle();
    write_cfg_reg(REG_THRESHOLD, 32'd1);
    send_event(MODE_MSG, 8'd9, KIND_TAGMSG);
    send_event(MODE_MSG, 8'd9, KIND_PRIVMSG);
    settle();
    write_cfg_reg(REG_THRESHOLD, 32'h0000_FFFF);
    write_cfg_reg(REG_WINDOW,    32'h000F_FFFF);
    write_cfg_reg(REG_PRIVMSG_W, 32'h0000_0FFF);
    send_event(MODE_MSG, 8'd9, KIND_PRIVMSG);
    send_event(MODE_MSG, 8'd9, KIND_PRIVMSG);
    settle();
  endtask

  // A zero-length window restarts after any tick; a one-second window needs two.
  task automatic test_window_restart();
    idle_pct = 0;
    write_cfg_reg(REG_THRESHOLD, 32'd2);
    write_cfg_reg(REG_WINDOW,    32'd0);
    write_cfg_reg(REG_PRIVMSG_W, 32'(ONE_FIXED));
    write_cfg_reg(REG_ACTION,    32'd3);
    send_event(MODE_MSG, 8'd20, KIND_PRIVMSG);
    send_event(MODE_TICK, 8'd20, KIND_PRIVMSG);
    send_event(MODE_MSG, 8'd20, KIND_PRIVMSG);
    send_event(MODE_MSG, 8'd20, KIND_PRIVMSG);
    settle();
    write_cfg_reg(REG_WINDOW, 32'd1);
    send_event(MODE_MSG, 8'd21, KIND_PRIVMSG);
    send_event(MODE_TICK, 8'd0, KIND_NOTICE);
    send_event(MODE_MSG, 8'd21, KIND_PRIVMSG);
    settle();
  endtask

  // Action codes are reported as written, those above the defined range too.
  task automatic test_action_codes();
    idle_pct = 74;
    write_cfg_reg(REG_THRESHOLD, 32'd0);
    write_cfg_reg(REG_ACTION, 32'd0);
    send_event(MODE_MSG, 8'd30, KIND_NOTICE);
    settle();
    write_cfg_reg(REG_ACTION, 32'd4);
    send_event(MODE_MSG, 8'd31, KIND_TAGMSG);
    settle();
    write_cfg_reg(REG_ACTION, 32'd7);
    send_event(MODE_MSG, 8'd32, KIND_PRIVMSG);
    settle();
  endtask

  // A count left above a newly lowered threshold fires even on a zero-weight message.
  task automatic test_lowered_threshold();
    idle_pct = 27;
    write_cfg_reg(REG_THRESHOLD, 32'd10);
    write_cfg_reg(REG_PRIVMSG_W, 32'(ONE_FIXED));
    repeat (3) send_event(MODE_MSG, 8'd40, KIND_PRIVMSG);
    settle();
    write_cfg_reg(REG_THRESHOLD, 32'd2);
    send_event(MODE_MSG, 8'd40, KIND_UNUSED);
    settle();
  endtask

  // Mostly repeated traffic from a few busy users so counts climb and fire, with
  // ticks for window restarts and some messages from arbitrary users.
  task automatic run_random_traffic(input int count);
    logic [SLOT_W-1:0] busy_users [6];
    int                roll;
    foreach (busy_users[i]) busy_users[i] = SLOT_W'($urandom);
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 12)
        send_event(MODE_TICK, SLOT_W'($urandom), KIND_W'($urandom));
      else if (roll < 85)
        send_event(MODE_MSG, busy_users[$urandom_range(5)], KIND_W'($urandom));
      else
        send_event(MODE_MSG, SLOT_W'($urandom), KIND_W'($urandom));
    end
    settle();
  endtask

  task automatic test_random_busy_sender();
    idle_pct = 27;
    program_detector($urandom_range(6, 2), $urandom_range(12, 3), $urandom_range(7, 0),
                     $urandom_range(600, 0), $urandom_range(600, 0), $urandom_range(600, 0));
    run_random_traffic(570);
  endtask

  task automatic test_random_sparse_sender();
    idle_pct = 74;
    program_detector($urandom_range(30, 8), 0, $urandom_range(7, 0),
                     $urandom_range(4095, 0), 0, 4095);
    run_random_traffic(570);
  endtask

  task automatic test_random_back_to_back();
    idle_pct = 0;
    program_detector($urandom_range(12, 2), $urandom_range(40, 1), $urandom_range(7, 0),
                     $urandom_range(600, 0), $urandom_range(600, 0), $urandom_range(600, 0));
    run_random_traffic(570);
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_mode         = MODE_MSG;
    in_user_slot    = '0;
    in_message_kind = KIND_PRIVMSG;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    failures        = 0;
    idle_pct        = 0;
    cycle_count     = 0;
    reset_shadow();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_threshold_edges();
    test_window_restart();
    test_action_codes();
    test_lowered_threshold();
    test_random_busy_sender();
    test_random_sparse_sender();
    test_random_back_to_back();

    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
